>>> rtl/bhrs_pkg.sv
// Shared types and constants for the byte histogram and run statistics unit.
package bhrs_pkg;

  localparam int unsigned VALUE_W = 8;
  localparam int unsigned OUT_W   = 32;

  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_END   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  localparam logic KIND_TOTALS = 1'b0;
  localparam logic KIND_CODE   = 1'b1;

endpackage

>>> rtl/bhrs_if.sv
// Valid/ready channel interfaces for the command and result words.
interface bhrs_in_if import bhrs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  logic [VALUE_W-1:0]   value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bhrs_out_if import bhrs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [VALUE_W-1:0]   code;
  logic [OUT_W-1:0]     occurrences;
  logic [OUT_W-1:0]     longest_run;
  logic [OUT_W-1:0]     multi_runs;
  logic [OUT_W-1:0]     total_bytes;
  logic [OUT_W-1:0]     total_run_bytes;

  modport source (output valid, output kind, output code, output occurrences,
                  output longest_run, output multi_runs, output total_bytes,
                  output total_run_bytes, input ready);
  modport sink   (input valid, input kind, input code, input occurrences,
                  input longest_run, input multi_runs, input total_bytes,
                  input total_run_bytes, output ready);
endinterface

>>> rtl/bhrs_stat_mem.sv
// Per-code statistics memory with registered read and per-entry valid bits.
module bhrs_stat_mem import bhrs_pkg::*; #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 96,
  parameter int unsigned AW    = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // An entry never written since reset or clear reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

>>> rtl/byte_histogram_run_stats_unit.sv
// Byte histogram with per-code run statistics: one command at a time through a
// read-modify-write of the statistics memory over its separate read and write
// ports. A data byte that continues the open run, or starts one when none is
// open, reads its entry and then writes the count; a data byte that closes a run
// and starts another does a close write, then a count write. An end first closes
// any open run; a read or an end then waits for the result register to drain. A
// clear needs no memory pass, since the entries are invalidated through flip-flop
// valid bits. The result register lets a new command be accepted while an earlier
// result still waits to be taken. Bytes and codes at or above CODE_COUNT are ignored, and read back as zero statistics.
module byte_histogram_run_stats_unit import bhrs_pkg::*; #(
  parameter int unsigned CODE_COUNT  = 256,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  bhrs_in_if.sink     in_ch,
  bhrs_out_if.source  out_ch
);

  localparam int unsigned AW = $clog2(CODE_COUNT);
  localparam int unsigned CW = COUNT_WIDTH;
  localparam int unsigned EW = 3 * CW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_COUNT,
    S_EMIT
  } state_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
    return (x == CNT_MAX) ? CNT_MAX : x + 1'b1;
  endfunction

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [CW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CW] ? CNT_MAX : sum[CW-1:0];
  endfunction

  // Counters wider than the result field show as all ones once they overflow it.
  function automatic logic [OUT_W-1:0] shown(input logic [CW-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[OUT_W-1:0];
  endfunction

  state_t          state_r;
  logic [AW-1:0]   prev_r;
  logic [CW-1:0]   run_len_r;
  logic            run_open_r;
  logic [CW-1:0]   byte_tot_r;
  logic [CW-1:0]   run_tot_r;
  logic [AW-1:0]   cur_r;
  logic            end_pend_r;
  logic            kind_r;
  logic            in_range_r;
  logic [VALUE_W-1:0] code_r;

  logic               out_valid_r;
  logic               out_kind_r;
  logic [VALUE_W-1:0] out_code_r;
  logic [OUT_W-1:0]   out_occ_r;
  logic [OUT_W-1:0]   out_long_r;
  logic [OUT_W-1:0]   out_multi_r;
  logic [OUT_W-1:0]   out_tot_r;
  logic [OUT_W-1:0]   out_run_tot_r;

  logic            in_fire;
  logic            clr_fire;
  logic            v_in_range;
  logic [AW-1:0]   v_idx;
  logic            same_run;
  logic            out_free;

  logic            mem_rd_en;
  logic [AW-1:0]   mem_rd_addr;
  logic            mem_wr_en;
  logic [AW-1:0]   mem_wr_addr;
  logic [EW-1:0]   mem_wr_data;
  logic [EW-1:0]   rd_entry;

  logic [CW-1:0]   ent_cnt;
  logic [CW-1:0]   ent_long;
  logic [CW-1:0]   ent_multi;
  logic [CW-1:0]   new_long;
  logic [CW-1:0]   new_multi;

  assign ent_cnt   = rd_entry[EW-1:2*CW];
  assign ent_long  = rd_entry[2*CW-1:CW];
  assign ent_multi = rd_entry[CW-1:0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign clr_fire    = in_fire && (in_ch.opcode == OP_CLEAR);
  assign v_in_range  = ({1'b0, in_ch.value} < 9'(CODE_COUNT));
  assign v_idx       = in_ch.value[AW-1:0];
  assign same_run    = run_open_r && (v_idx == prev_r);
  assign out_free    = !out_valid_r || out_ch.ready;

  assign new_long  = (ent_long < run_len_r) ? run_len_r : ent_long;
  assign new_multi = (run_len_r > CW'(1)) ? sat_inc(ent_multi) : ent_multi;

  // Memory access sequencing. Writes and reads within one command never hit the
  // same entry in the same cycle, so no forwarding is needed.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = v_idx;
    mem_wr_en   = 1'b0;
    mem_wr_addr = cur_r;
    mem_wr_data = {sat_inc(ent_cnt), ent_long, ent_multi};
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_DATA: begin
              mem_rd_en = v_in_range;
              if (run_open_r && !same_run) begin
                mem_rd_addr = prev_r;
              end
            end
            OP_END: begin
              mem_rd_en   = run_open_r;
              mem_rd_addr = prev_r;
            end
            OP_READ: begin
              mem_rd_en = v_in_range;
            end
            default: begin
              mem_rd_en = 1'b0;
            end
          endcase
        end
      end
      S_CLOSE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = prev_r;
        mem_wr_data = {ent_cnt, new_long, new_multi};
        mem_rd_en   = !end_pend_r;
        mem_rd_addr = cur_r;
      end
      S_COUNT: begin
        mem_wr_en = 1'b1;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  bhrs_stat_mem #(
    .DEPTH (CODE_COUNT),
    .WIDTH (EW),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (clr_fire),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      run_len_r   <= '0;
      run_open_r  <= 1'b0;
      byte_tot_r  <= '0;
      run_tot_r   <= '0;
      end_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // In S_EMIT the result register is reloaded whenever it drains.
      if (out_valid_r && out_ch.ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            cur_r      <= v_idx;
            code_r     <= in_ch.value;
            in_range_r <= v_in_range;
            case (in_ch.opcode)
              OP_DATA: begin
                end_pend_r <= 1'b0;
                if (v_in_range) begin
                  byte_tot_r <= sat_inc(byte_tot_r);
                  if (same_run) begin
                    run_len_r <= sat_inc(run_len_r);
                    state_r   <= S_COUNT;
                  end else if (run_open_r) begin
                    state_r <= S_CLOSE;
                  end else begin
                    prev_r     <= v_idx;
                    run_len_r  <= CW'(1);
                    run_open_r <= 1'b1;
                    state_r    <= S_COUNT;
                  end
                end
              end
              OP_END: begin
                end_pend_r <= 1'b1;
                kind_r     <= KIND_TOTALS;
                state_r    <= run_open_r ? S_CLOSE : S_EMIT;
              end
              OP_READ: begin
                kind_r  <= KIND_CODE;
                state_r <= S_EMIT;
              end
              default: begin
                prev_r     <= '0;
                run_len_r  <= '0;
                run_open_r <= 1'b0;
                byte_tot_r <= '0;
                run_tot_r  <= '0;
              end
            endcase
          end
        end
        S_CLOSE: begin
          run_tot_r <= sat_add(run_tot_r, run_len_r);
          if (end_pend_r) begin
            run_open_r <= 1'b0;
            run_len_r  <= '0;
            state_r    <= S_EMIT;
          end else begin
            prev_r     <= cur_r;
            run_len_r  <= CW'(1);
            run_open_r <= 1'b1;
            state_r    <= S_COUNT;
          end
        end
        S_COUNT: begin
          state_r <= S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_kind_r    <= kind_r;
            out_code_r    <= (kind_r == KIND_CODE) ? code_r : '0;
            out_tot_r     <= shown(byte_tot_r);
            out_run_tot_r <= shown(run_tot_r);
            if ((kind_r == KIND_CODE) && in_range_r) begin
              out_occ_r   <= shown(ent_cnt);
              out_long_r  <= shown(ent_long);
              out_multi_r <= shown(ent_multi);
            end else begin
              out_occ_r   <= '0;
              out_long_r  <= '0;
              out_multi_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.kind            = out_kind_r;
  assign out_ch.code            = out_code_r;
  assign out_ch.occurrences     = out_occ_r;
  assign out_ch.longest_run     = out_long_r;
  assign out_ch.multi_runs      = out_multi_r;
  assign out_ch.total_bytes     = out_tot_r;
  assign out_ch.total_run_bytes = out_run_tot_r;

  // A clear word leaves every running total and the open run empty.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    clr_fire |=> (byte_tot_r == '0) && (run_tot_r == '0) && !run_open_r)
    else $error("clear did not empty the running state");

  // An open run always holds at least one byte while the unit waits for a word.
  a_open_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) && run_open_r |-> (run_len_r != '0))
    else $error("open run with zero length");

  // The closed-run total only grows, except on clear.
  a_run_tot_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(clr_fire) |-> (run_tot_r >= $past(run_tot_r)))
    else $error("closed-run total decreased");

  // A pending result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready && (state_r == S_EMIT) |=> (state_r == S_EMIT))
    else $error("result register overwritten while stalled");

endmodule

>>> tb/bhrs_scoreboard.sv
// Scoreboard that predicts and checks the report words of the byte histogram unit.
`timescale 1ns / 1ps

module bhrs_scoreboard import bhrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bhrs_in_if          cmd_mon,
  bhrs_out_if         rpt_mon,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned reports_seen
);

  localparam int unsigned CODES = 256;
  localparam logic [OUT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] code;
    logic [OUT_W-1:0]   occurrences;
    logic [OUT_W-1:0]   longest_run;
    logic [OUT_W-1:0]   multi_runs;
    logic [OUT_W-1:0]   total_bytes;
    logic [OUT_W-1:0]   total_run_bytes;
  } report_t;

  logic [OUT_W-1:0]   occ_tbl     [CODES];
  logic [OUT_W-1:0]   longest_tbl [CODES];
  logic [OUT_W-1:0]   multi_tbl   [CODES];
  logic [VALUE_W-1:0] last_byte;
  logic [OUT_W-1:0]   run_len;
  bit                 run_active;
  logic [OUT_W-1:0]   byte_cnt;
  logic [OUT_W-1:0]   run_byte_cnt;

  report_t     expected_reports[$];
  int unsigned mismatch_cnt = 0;
  int unsigned queued_cnt   = 0;
  int unsigned report_cnt   = 0;

  assign errors       = mismatch_cnt;
  assign pending      = queued_cnt;
  assign reports_seen = report_cnt;

  function automatic logic [OUT_W-1:0] sat_inc(logic [OUT_W-1:0] x);
    return (x == COUNT_SAT) ? COUNT_SAT : x + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] sat_add(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
    logic [OUT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[OUT_W] ? COUNT_SAT : sum[OUT_W-1:0];
  endfunction

  task automatic clear_stats();
    for (int i = 0; i < CODES; i++) begin
      occ_tbl[i]     = '0;
      longest_tbl[i] = '0;
      multi_tbl[i]   = '0;
    end
    last_byte    = '0;
    run_len      = '0;
    run_active   = 1'b0;
    byte_cnt     = '0;
    run_byte_cnt = '0;
  endtask

  // Only a closed run reaches the longest-run table, the multi-run table and
  // the run-byte total.
  task automatic close_run();
    if (run_active) begin
      run_byte_cnt = sat_add(run_byte_cnt, run_len);
      if (longest_tbl[last_byte] < run_len) longest_tbl[last_byte] = run_len;
      if (run_len > 1) multi_tbl[last_byte] = sat_inc(multi_tbl[last_byte]);
      run_active = 1'b0;
      run_len    = '0;
    end
  endtask

  // With 256 codes every 8-bit value is a valid code, so no byte is ignored.
  task automatic apply_command(opcode_t op, logic [VALUE_W-1:0] v);
    report_t rep;
    rep = '0;
    case (op)
      OP_DATA: begin
        byte_cnt   = sat_inc(byte_cnt);
        occ_tbl[v] = sat_inc(occ_tbl[v]);
        if (run_active && v == last_byte) begin
          run_len = sat_inc(run_len);
        end else begin
          close_run();
          last_byte  = v;
          run_len    = 1;
          run_active = 1'b1;
        end
      end
      OP_END: begin
        close_run();
        rep.kind            = KIND_TOTALS;
        rep.total_bytes     = byte_cnt;
        rep.total_run_bytes = run_byte_cnt;
        expected_reports.push_back(rep);
      end
      OP_READ: begin
        rep.kind            = KIND_CODE;
        rep.code            = v;
        rep.occurrences     = occ_tbl[v];
        rep.longest_run     = longest_tbl[v];
        rep.multi_runs      = multi_tbl[v];
        rep.total_bytes     = byte_cnt;
        rep.total_run_bytes = run_byte_cnt;
        expected_reports.push_back(rep);
      end
      default: begin
        clear_stats();
      end
    endcase
  endtask

  function automatic int unsigned field_diff(string name, logic [OUT_W-1:0] want,
                                             logic [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_report();
    report_t want;
    report_t got;
    got.kind            = rpt_mon.kind;
    got.code            = rpt_mon.code;
    got.occurrences     = rpt_mon.occurrences;
    got.longest_run     = rpt_mon.longest_run;
    got.multi_runs      = rpt_mon.multi_runs;
    got.total_bytes     = rpt_mon.total_bytes;
    got.total_run_bytes = rpt_mon.total_run_bytes;
    report_cnt++;
    if (expected_reports.size() == 0) begin
      $display("%0t: report word with none expected, expected nothing got kind %0d code %0d",
               $time, got.kind, got.code);
      mismatch_cnt++;
    end else begin
      want = expected_reports.pop_front();
      mismatch_cnt += field_diff("kind", OUT_W'(want.kind), OUT_W'(got.kind))
                    + field_diff("code", OUT_W'(want.code), OUT_W'(got.code))
                    + field_diff("occurrences", want.occurrences, got.occurrences)
                    + field_diff("longest_run", want.longest_run, got.longest_run)
                    + field_diff("multi_runs", want.multi_runs, got.multi_runs)
                    + field_diff("total_bytes", want.total_bytes, got.total_bytes)
                    + field_diff("total_run_bytes", want.total_run_bytes,
                                 got.total_run_bytes);
    end
  endtask

  // The report taken at an edge always belongs to an earlier command, so it
  // is checked before the command taken at the same edge is applied.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_stats();
      expected_reports.delete();
    end else begin
      if (rpt_mon.valid && rpt_mon.ready) check_report();
      if (cmd_mon.valid && cmd_mon.ready) apply_command(cmd_mon.opcode, cmd_mon.value);
    end
    queued_cnt = expected_reports.size();
  end

endmodule

>>> tb/byte_histogram_run_stats_unit_tb.sv
// Top level of the byte histogram unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module byte_histogram_run_stats_unit_tb;
  import bhrs_pkg::*;

  localparam int unsigned RANDOM_WORDS = 650;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic clk = 1'b0;
  logic rst_n;

  bhrs_in_if  cmd_ch ();
  bhrs_out_if rpt_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned reports_seen;

  int unsigned cycle_cnt = 0;
  int unsigned sent_words = 0;
  int unsigned sent_data = 0;
  int unsigned sent_reads = 0;
  int unsigned sent_ends = 0;
  int unsigned sent_clears = 0;
  int unsigned taken_reports = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          held_off = 1'b0;
  logic [VALUE_W-1:0] code_pool [8];

  always #1 clk = ~clk;

  byte_histogram_run_stats_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (rpt_ch)
  );

  bhrs_scoreboard i_scoreboard (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_mon      (cmd_ch),
    .rpt_mon      (rpt_ch),
    .errors       (errors),
    .pending      (pending),
    .reports_seen (reports_seen)
  );

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d reports outstanding", cycle_cnt, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_code();
    if ($urandom_range(0, 3) != 0) return code_pool[$urandom_range(0, 7)];
    return VALUE_W'($urandom_range(0, 255));
  endfunction

  // Offers one command word after a random gap and returns once it is taken.
  task automatic send_word(input opcode_t op, input logic [VALUE_W-1:0] val);
    int unsigned gap;
    gap = draw_gap(send_quiet);
    @(negedge clk);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.opcode <= op;
    cmd_ch.value  <= val;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    sent_words++;
    case (op)
      OP_DATA:  sent_data++;
      OP_END:   sent_ends++;
      OP_READ:  sent_reads++;
      default:  sent_clears++;
    endcase
    if (sent_words % 48 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: random stalls per word, and one long hold-off mid-run so
  // that the unit backs up into its command input.
  initial begin
    int unsigned gap;
    rpt_ch.ready = 1'b0;
    forever begin
      if (!held_off && sent_words >= HOLD_AFTER) begin
        @(negedge clk);
        rpt_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held_off = 1'b1;
      end
      gap = draw_gap(recv_quiet);
      @(negedge clk);
      if (gap > 0) begin
        rpt_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rpt_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rpt_ch.valid) @(posedge clk);
      taken_reports++;
      if (taken_reports % 32 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int unsigned pick;
    int unsigned run;
    int unsigned target;
    logic [VALUE_W-1:0] code;
    rst_n         = 1'b0;
    cmd_ch.valid  = 1'b0;
    cmd_ch.opcode = OP_DATA;
    cmd_ch.value  = '0;
    code_pool[0]  = 8'h00;
    code_pool[1]  = 8'hFF;
    for (int i = 2; i < 8; i++) code_pool[i] = VALUE_W'($urandom_range(0, 255));
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // Empty tables, then runs of both extreme codes and of alternating bit
    // patterns, reads during an open run, ends with and without an open run,
    // a run restarted right after an end, and reads after a clear.
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'hFF);
    send_word(OP_END, 8'h00);
    repeat (3) send_word(OP_DATA, 8'h00);
    repeat (2) send_word(OP_DATA, 8'hFF);
    send_word(OP_DATA, 8'h55);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'hFF);
    send_word(OP_READ, 8'h55);
    send_word(OP_END, 8'hFF);
    send_word(OP_END, 8'hAA);
    send_word(OP_DATA, 8'h55);
    repeat (2) send_word(OP_DATA, 8'hAA);
    send_word(OP_READ, 8'h55);
    send_word(OP_READ, 8'hAA);
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_READ, 8'h00);
    send_word(OP_END, 8'h55);

    // Mostly runs over a small set of codes, with reads of those codes,
    // ends, rare clears and some fully random words.
    target = sent_words + RANDOM_WORDS;
    while (sent_words < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        code = pick_code();
        run  = $urandom_range(1, 6);
        repeat (run) send_word(OP_DATA, code);
      end else if (pick < 75) begin
        send_word(OP_READ, pick_code());
      end else if (pick < 87) begin
        send_word(OP_END, VALUE_W'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        send_word(OP_CLEAR, VALUE_W'($urandom_range(0, 255)));
      end else begin
        send_word(opcode_t'($urandom_range(0, 3)), VALUE_W'($urandom_range(0, 255)));
      end
    end
    @(negedge clk);
    cmd_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Sent %0d words: %0d data, %0d reads, %0d ends, %0d clears",
             sent_words, sent_data, sent_reads, sent_ends, sent_clears);
    $display("Checked %0d reports; result side held off %0d cycles once, %0d mismatches",
             reports_seen, HOLD_CYCLES, errors);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/bhrs_pkg.sv
rtl/bhrs_if.sv
rtl/bhrs_stat_mem.sv
rtl/byte_histogram_run_stats_unit.sv
tb/bhrs_scoreboard.sv
tb/byte_histogram_run_stats_unit_tb.sv
